@@ hw/rtl/srmp_pkg.sv @@
// Shared types, constants and the microprogram for the stepper speed ramp.
// Used by the sequencer, the datapath, the divider and the top level.
package srmp_pkg;

   localparam int unsigned STEP_W     = 4;
   localparam int unsigned SPEED_W    = 14;
   localparam int unsigned FREQ_W     = 14;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned ACCUM_W    = 31;
   localparam int unsigned ELAPSED_W  = 30;
   localparam int unsigned DIV_BITS   = 20;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 30;

   localparam logic [DIV_BITS-1:0]  DIVIDEND      = 20'd1000000;
   localparam logic [FREQ_W-1:0]    SPEED_OFFSET  = 14'd100;
   localparam logic [ACCUM_W-1:0]   ONE_SECOND_NS = 31'd1000000000;
   localparam logic [ACCUM_W-1:0]   ACCUM_MAX     = 31'h7FFF_FFFF;
   localparam logic signed [15:0]   SPEED_LIMIT   = 16'sd8191;

   localparam logic [13:0] ACCEL_RESET     = 14'd15;
   localparam logic [29:0] INTERVAL_RESET  = 30'd10000;
   localparam logic [12:0] SPEED_MIN_RESET = 13'd1;
   localparam logic [12:0] SPEED_MAX_RESET = 13'd5782;
   localparam logic [13:0] FREQ_MIN_RESET  = 14'd100;
   localparam logic [13:0] FREQ_MAX_RESET  = 14'd5882;
   localparam logic [15:0] PER_MIN_RESET   = 16'd170;
   localparam logic [15:0] PER_MAX_RESET   = 16'd10000;

   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FREQ_MIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FREQ_MAX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_MIN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_MAX    = 3'd7;

   localparam logic [1:0] DUTY_ZERO  = 2'd0;
   localparam logic [1:0] DUTY_HALF  = 2'd1;
   localparam logic [1:0] DUTY_SIXTY = 2'd2;

   typedef logic [STEP_W-1:0] step_addr_type;

   localparam step_addr_type STEP_IDLE     = 4'd0;
   localparam step_addr_type STEP_ACCUM    = 4'd1;
   localparam step_addr_type STEP_TEST     = 4'd2;
   localparam step_addr_type STEP_DIFF     = 4'd3;
   localparam step_addr_type STEP_NOMINAL  = 4'd4;
   localparam step_addr_type STEP_MOVE     = 4'd5;
   localparam step_addr_type STEP_MAP      = 4'd6;
   localparam step_addr_type STEP_LOW      = 4'd7;
   localparam step_addr_type STEP_HIGH     = 4'd8;
   localparam step_addr_type STEP_DIV_GO   = 4'd9;
   localparam step_addr_type STEP_DIV_WAIT = 4'd10;
   localparam step_addr_type STEP_DIV_END  = 4'd11;
   localparam step_addr_type STEP_EMIT     = 4'd12;
   localparam step_addr_type STEP_RETURN   = 4'd13;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_ACCUM,
      OP_DIFF,
      OP_NOMINAL,
      OP_MOVE,
      OP_MAP,
      OP_LOW,
      OP_HIGH,
      OP_DIV_START,
      OP_DIV_END,
      OP_EMIT
   } srmp_op_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NOT_DUE,
      COND_REACHED,
      COND_LOW_FREQ,
      COND_HIGH_FREQ,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } srmp_cond_type;

   typedef struct packed {
      srmp_op_type   op;
      srmp_cond_type cond;
      step_addr_type target;
   } srmp_ctrl_type;

   typedef struct packed {
      logic no_req;
      logic not_due;
      logic reached;
      logic low_freq;
      logic high_freq;
      logic div_busy;
      logic out_busy;
   } srmp_status_type;

   function automatic srmp_ctrl_type srmp_rom(input step_addr_type addr);
      srmp_ctrl_type word;
      case (addr)
         STEP_IDLE:     word = '{OP_LOAD,      COND_NO_REQ,    STEP_IDLE};
         STEP_ACCUM:    word = '{OP_ACCUM,     COND_NONE,      STEP_IDLE};
         STEP_TEST:     word = '{OP_NOP,       COND_NOT_DUE,   STEP_EMIT};
         STEP_DIFF:     word = '{OP_DIFF,      COND_NONE,      STEP_IDLE};
         STEP_NOMINAL:  word = '{OP_NOMINAL,   COND_REACHED,   STEP_EMIT};
         STEP_MOVE:     word = '{OP_MOVE,      COND_NONE,      STEP_IDLE};
         STEP_MAP:      word = '{OP_MAP,       COND_NONE,      STEP_IDLE};
         STEP_LOW:      word = '{OP_LOW,       COND_LOW_FREQ,  STEP_EMIT};
         STEP_HIGH:     word = '{OP_HIGH,      COND_HIGH_FREQ, STEP_EMIT};
         STEP_DIV_GO:   word = '{OP_DIV_START, COND_NONE,      STEP_IDLE};
         STEP_DIV_WAIT: word = '{OP_NOP,       COND_DIV_BUSY,  STEP_DIV_WAIT};
         STEP_DIV_END:  word = '{OP_DIV_END,   COND_NONE,      STEP_IDLE};
         STEP_EMIT:     word = '{OP_EMIT,      COND_OUT_BUSY,  STEP_EMIT};
         STEP_RETURN:   word = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
         default:       word = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

@@ hw/rtl/srmp_seq.sv @@
// Microprogram sequencer: step counter, control word lookup and jumps.
// Depends on srmp_pkg for the control word, status struct and program.
module srmp_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  srmp_pkg::srmp_status_type status,
   output srmp_pkg::srmp_ctrl_type   ctrl
);
   import srmp_pkg::*;

   step_addr_type pc_ff;
   step_addr_type pc_in;
   logic          take_jump;

   assign ctrl = srmp_rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NONE:      take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NO_REQ:    take_jump = status.no_req;
         COND_NOT_DUE:   take_jump = status.not_due;
         COND_REACHED:   take_jump = status.reached;
         COND_LOW_FREQ:  take_jump = status.low_freq;
         COND_HIGH_FREQ: take_jump = status.high_freq;
         COND_DIV_BUSY:  take_jump = status.div_busy;
         COND_OUT_BUSY:  take_jump = status.out_busy;
         default:        take_jump = 1'b1;
      endcase
      pc_in = take_jump ? ctrl.target : step_addr_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hw/rtl/srmp_div.sv @@
// Restoring divider that forms the fixed dividend over one bit per cycle.
// Depends on srmp_pkg for the dividend and widths.
module srmp_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [srmp_pkg::FREQ_W-1:0]         divisor,
   output logic                                busy,
   output logic [srmp_pkg::DIV_BITS-1:0]       quotient
);
   import srmp_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_BITS);

   logic                busy_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [FREQ_W-1:0]   rem_ff;
   logic [FREQ_W-1:0]   div_ff;
   logic [DIV_BITS-1:0] quo_ff;
   logic [FREQ_W:0]     shifted;
   logic [FREQ_W:0]     trial;
   logic                fits;

   assign shifted  = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial    = shifted - {1'b0, div_ff};
   assign fits     = shifted >= {1'b0, div_ff};
   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && count_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= CNT_W'(DIV_BITS - 1);
         rem_ff   <= '0;
         div_ff   <= divisor;
         quo_ff   <= DIVIDEND;
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         rem_ff   <= fits ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];
         quo_ff   <= {quo_ff[DIV_BITS-2:0], fits};
      end
   end

endmodule

@@ hw/rtl/srmp_dp.sv @@
// Datapath of the speed ramp: settings, ramp state, PWM mapping and result register.
// Depends on srmp_pkg; driven by the control word from srmp_seq.
module srmp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  srmp_pkg::srmp_ctrl_type             ctrl,
   output srmp_pkg::srmp_status_type           status,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srmp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srmp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [srmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srmp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                div_busy,
   input  logic [srmp_pkg::DIV_BITS-1:0]       div_quotient,
   output logic                                div_start,
   output logic [srmp_pkg::FREQ_W-1:0]         div_divisor
);
   import srmp_pkg::*;

   logic [13:0] accel_ff;
   logic [29:0] interval_ff;
   logic [12:0] smin_ff;
   logic [12:0] smax_ff;
   logic [13:0] fmin_ff;
   logic [13:0] fmax_ff;
   logic [15:0] pmin_ff;
   logic [15:0] pmax_ff;

   logic signed [SPEED_W-1:0] target_ff;
   logic signed [SPEED_W-1:0] corr_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;

   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      reached_ff, reached_in;
   logic [13:0]               applied_ff, applied_in;
   logic signed [14:0]        nominal_ff, nominal_in;
   logic [ACCUM_W-1:0]        accum_ff, accum_in;
   logic                      dir_ff, dir_in;
   logic [PERIOD_W-1:0]       period_ff, period_in;
   logic [1:0]                duty_ff, duty_in;
   logic                      taken_ff, taken_in;
   logic [14:0]               diff_ff, diff_in;
   logic [14:0]               ndiff_ff, ndiff_in;
   logic [FREQ_W-1:0]         freq_ff, freq_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   logic [ACCUM_W:0]          accum_sum;
   logic                      due;
   logic signed [15:0]        goal_diff;
   logic [15:0]               goal_abs;
   logic signed [14:0]        targ_diff;
   logic [14:0]               targ_abs;
   logic [13:0]               nom_mag;
   logic [13:0]               move_mag;
   logic signed [15:0]        move_sum;
   logic [12:0]               speed_mag;
   logic [FREQ_W-1:0]         clamp_val;
   logic                      load_req;
   logic                      emit;

   assign load_req = ctrl.op == OP_LOAD && req_tvalid;
   assign emit     = ctrl.op == OP_EMIT && !status.out_busy;

   assign accum_sum = {1'b0, accum_ff} + {2'b00, elapsed_ff};
   assign due       = accum_ff >= ONE_SECOND_NS || accum_ff > {1'b0, interval_ff};

   assign goal_diff = 16'(target_ff) + 16'(corr_ff) - 16'(speed_ff);
   assign goal_abs  = goal_diff[15] ? 16'(-goal_diff) : 16'(goal_diff);
   assign targ_diff = 15'(target_ff) - 15'(speed_ff);
   assign targ_abs  = targ_diff[14] ? 15'(-targ_diff) : 15'(targ_diff);

   assign nom_mag  = ndiff_ff < {1'b0, accel_ff} ? ndiff_ff[13:0] : accel_ff;
   assign move_mag = diff_ff < {1'b0, accel_ff} ? diff_ff[13:0] : accel_ff;
   assign move_sum = (target_ff > speed_ff)
                     ? 16'(speed_ff) + $signed({2'b00, move_mag})
                     : 16'(speed_ff) - $signed({2'b00, move_mag});

   assign speed_mag = speed_ff[SPEED_W-1] ? 13'(-speed_ff) : 13'(speed_ff);

   always_comb begin
      if (speed_mag < smin_ff) begin
         clamp_val = {1'b0, smin_ff};
      end else if (speed_mag > smax_ff) begin
         clamp_val = {1'b0, smax_ff};
      end else begin
         clamp_val = FREQ_W'(speed_mag) + SPEED_OFFSET;
      end
   end

   assign status.no_req    = !req_tvalid;
   assign status.not_due   = !due;
   assign status.reached   = diff_ff == '0;
   assign status.low_freq  = freq_ff <= fmin_ff;
   assign status.high_freq = freq_ff >= fmax_ff;
   assign status.div_busy  = div_busy;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   assign req_tready  = ctrl.op == OP_LOAD;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign div_start   = ctrl.op == OP_DIV_START;
   assign div_divisor = freq_ff;

   always_comb begin
      speed_in     = speed_ff;
      reached_in   = reached_ff;
      applied_in   = applied_ff;
      nominal_in   = nominal_ff;
      accum_in     = accum_ff;
      dir_in       = dir_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      taken_in     = taken_ff;
      diff_in      = diff_ff;
      ndiff_in     = ndiff_ff;
      freq_in      = freq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (ctrl.op)
         OP_LOAD: begin
            if (req_tvalid) begin
               taken_in = 1'b0;
            end
         end
         OP_ACCUM: begin
            accum_in = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];
         end
         OP_DIFF: begin
            taken_in = 1'b1;
            accum_in = '0;
            diff_in  = goal_abs[14:0];
            ndiff_in = targ_abs;
         end
         OP_NOMINAL: begin
            nominal_in = target_ff[SPEED_W-1] ? 15'(-$signed({1'b0, nom_mag}))
                                              : $signed({1'b0, nom_mag});
            if (diff_ff == '0) begin
               reached_in = 1'b1;
               applied_in = '0;
            end
         end
         OP_MOVE: begin
            reached_in = 1'b0;
            applied_in = move_mag;
            if (move_sum > SPEED_LIMIT) begin
               speed_in = SPEED_W'(SPEED_LIMIT);
            end else if (move_sum < -SPEED_LIMIT) begin
               speed_in = SPEED_W'(-SPEED_LIMIT);
            end else begin
               speed_in = move_sum[SPEED_W-1:0];
            end
         end
         OP_MAP: begin
            if (speed_ff == '0) begin
               freq_in = SPEED_OFFSET;
               dir_in  = 1'b0;
            end else begin
               freq_in = clamp_val;
               dir_in  = speed_ff[SPEED_W-1] || clamp_val == '0;
            end
         end
         OP_LOW: begin
            if (status.low_freq) begin
               period_in = pmax_ff;
               duty_in   = DUTY_ZERO;
            end
         end
         OP_HIGH: begin
            if (status.high_freq) begin
               period_in = pmin_ff;
               duty_in   = DUTY_SIXTY;
            end
         end
         OP_DIV_END: begin
            period_in = (|div_quotient[DIV_BITS-1:PERIOD_W]) ? '1
                                                           : div_quotient[PERIOD_W-1:0];
            duty_in   = DUTY_HALF;
         end
         OP_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= '0;
         reached_ff   <= 1'b1;
         applied_ff   <= '0;
         nominal_ff   <= '0;
         accum_ff     <= '0;
         dir_ff       <= 1'b0;
         period_ff    <= PER_MAX_RESET;
         duty_ff      <= DUTY_ZERO;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         speed_ff     <= speed_in;
         reached_ff   <= reached_in;
         applied_ff   <= applied_in;
         nominal_ff   <= nominal_in;
         accum_ff     <= accum_in;
         dir_ff       <= dir_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      ndiff_ff <= ndiff_in;
      freq_ff  <= freq_in;
      if (load_req) begin
         target_ff  <= req_tdata[13:0];
         corr_ff    <= req_tdata[27:14];
         elapsed_ff <= req_tdata[57:28];
      end
      if (emit) begin
         rsp_data_ff <= {duty_ff, period_ff, dir_ff, nominal_ff, applied_ff,
                         speed_ff, reached_ff, taken_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff    <= ACCEL_RESET;
         interval_ff <= INTERVAL_RESET;
         smin_ff     <= SPEED_MIN_RESET;
         smax_ff     <= SPEED_MAX_RESET;
         fmin_ff     <= FREQ_MIN_RESET;
         fmax_ff     <= FREQ_MAX_RESET;
         pmin_ff     <= PER_MIN_RESET;
         pmax_ff     <= PER_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACCEL_STEP:    accel_ff    <= csr_wdata[13:0];
            REG_STEP_INTERVAL: interval_ff <= csr_wdata[29:0];
            REG_SPEED_MIN:     smin_ff     <= csr_wdata[12:0];
            REG_SPEED_MAX:     smax_ff     <= csr_wdata[12:0];
            REG_FREQ_MIN:      fmin_ff     <= csr_wdata[13:0];
            REG_FREQ_MAX:      fmax_ff     <= csr_wdata[13:0];
            REG_PERIOD_MIN:    pmin_ff     <= csr_wdata[15:0];
            REG_PERIOD_MAX:    pmax_ff     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/stepper_speed_ramp.sv @@
// Stepper speed ramp: one result per request, one request at a time.
// A request with no ramp step due goes straight to the result; a due step forms the
// difference and nominal step, moves the speed unless reached, maps it to a frequency
// and sets the PWM period from the frequency limits or from the bit-serial divider that
// forms 1000000 / frequency. A new request is taken only once the result is registered.
// Synchronous reset restores the register defaults and clears the ramp state.
module stepper_speed_ramp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // target_speed[13:0], correction[27:14], elapsed_ns[57:28], zero[63:58]
   input  logic [srmp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // step_taken[0], speed_reached[1], current_speed[15:2], last_step[29:16],
   // nominal_step[44:30], motor_direction[45], pwm_period_us[61:46], duty_code[63:62]
   output logic [srmp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [srmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srmp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import srmp_pkg::*;

   srmp_ctrl_type       ctrl;
   srmp_status_type     status;
   logic                div_busy;
   logic                div_start;
   logic [FREQ_W-1:0]   div_divisor;
   logic [DIV_BITS-1:0] div_quotient;

   srmp_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   srmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   srmp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .div_busy     (div_busy),
      .div_quotient (div_quotient),
      .div_start    (div_start),
      .div_divisor  (div_divisor)
   );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stepper_speed_ramp: a directed table, then random requests
// over several register settings, each response checked against the ramp predictor or a known value.
// Depends only on srmp_pkg and the stepper_speed_ramp RTL.
module tb;
   import srmp_pkg::*;

   localparam int     QUIET_LIMIT = 2000;
   localparam int     PHASE_ITEMS = 315;
   localparam int     TAIL_CYCLES = 40;
   localparam longint ONE_SEC     = 1000000000;
   localparam longint ACCUM_TOP   = 64'h7FFF_FFFF;
   localparam int     EL_TOP      = 1073741823;
   localparam int     SPD_TOP     = 8191;
   localparam int     PERIOD_TOP  = 65535;

   // Response fields from the most significant end down.
   typedef struct packed {
      logic [1:0]  duty;
      logic [15:0] period;
      logic        dir;
      logic [14:0] nominal;
      logic [13:0] last;
      logic [13:0] speed;
      logic        reached;
      logic        taken;
   } ramp_status_type;

   typedef struct {
      int accel;
      int interval;
      int smin;
      int smax;
      int fmin;
      int fmax;
      int pmin;
      int pmax;
   } ramp_cfg_type;

   typedef enum {PLAN_UPDATE, PLAN_KNOWN, PLAN_WRITE} plan_kind_type;

   typedef struct {
      plan_kind_type          kind;
      int                     tgt;
      int                     corr;
      int                     el;
      ramp_status_type        want;
      logic [CSR_IDX_W-1:0]   idx;
      int                     val;
   } plan_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   ramp_cfg_type    cfg;
   int              ramp_speed;
   int              ramp_applied;
   int              ramp_nominal;
   int              pwm_period;
   logic            ramp_reached;
   logic            pwm_dir;
   logic [1:0]      pwm_duty;
   longint          ramp_accum;
   ramp_status_type status_due[$];
   int              n_errors     = 0;
   int              quiet_cycles = 0;
   int              tx_idle_pct  = 7;
   int              rx_idle_pct  = 64;

   // The first rows can be read straight off the reset state; the rest go through
   // the predictor. Register writes move into saturation, clamp and divider corners.
   plan_row_type directed_plan [30] = '{
      '{PLAN_KNOWN, 0, 0, 0,
        '{DUTY_ZERO, 16'd10000, 1'b0, 15'sd0, 14'd0, 14'sd0, 1'b1, 1'b0}, '0, 0},
      '{PLAN_KNOWN, 8191, 0, 10001,
        '{DUTY_HALF, 16'd8695, 1'b0, 15'sd15, 14'd15, 14'sd15, 1'b0, 1'b1}, '0, 0},
      '{PLAN_KNOWN, -8192, -8192, 1000000000,
        '{DUTY_ZERO, 16'd10000, 1'b0, -15'sd15, 14'd15, 14'sd0, 1'b0, 1'b1}, '0, 0},
      '{PLAN_UPDATE, 0, 0, 10000, '0, '0, 0},
      '{PLAN_UPDATE, 0, 0, 1, '0, '0, 0},
      '{PLAN_UPDATE, 100, -100, 20000, '0, '0, 0},
      '{PLAN_UPDATE, 8191, 8191, 1073741823, '0, '0, 0},
      '{PLAN_UPDATE, -50, 0, 0, '0, '0, 0},
      '{PLAN_UPDATE, -8192, 8191, 12345, '0, '0, 0},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_ACCEL_STEP, 16383},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_FREQ_MAX, 1000},
      '{PLAN_UPDATE, 8191, 8191, 10001, '0, '0, 0},
      '{PLAN_UPDATE, 8191, 8191, 10001, '0, '0, 0},
      '{PLAN_UPDATE, -8192, -8192, 10001, '0, '0, 0},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_SPEED_MAX, 0},
      '{PLAN_UPDATE, 500, 0, 10001, '0, '0, 0},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_SPEED_MAX, 5782},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_SPEED_MIN, 10},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_FREQ_MIN, 0},
      '{PLAN_UPDATE, 5, 0, 10001, '0, '0, 0},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_ACCEL_STEP, 0},
      '{PLAN_UPDATE, 1000, 0, 10001, '0, '0, 0},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_ACCEL_STEP, 15},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_SPEED_MIN, 1},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_FREQ_MIN, 100},
      '{PLAN_WRITE, 0, 0, 0, '0, REG_FREQ_MAX, 5882},
      '{PLAN_UPDATE, -1, 1, 10001, '0, '0, 0},
      '{PLAN_UPDATE, 1, 0, 10001, '0, '0, 0},
      '{PLAN_UPDATE, -300, 0, 999999999, '0, '0, 0},
      '{PLAN_UPDATE, 0, -8192, 10001, '0, '0, 0}
   };

   stepper_speed_ramp u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic ramp_status_type advance_ramp(input int tgt, input int corr,
                                                    input int el);
      ramp_status_type st;
      longint          sum;
      int              diff;
      int              ndiff;
      int              step;
      int              s;
      int              freq;
      int              q;
      logic            taken;
      taken = 1'b0;
      sum = ramp_accum + el;
      ramp_accum = (sum > ACCUM_TOP) ? ACCUM_TOP : sum;
      if (ramp_accum >= ONE_SEC || ramp_accum > cfg.interval) begin
         taken = 1'b1;
         ramp_accum = 0;
         diff = tgt + corr - ramp_speed;
         if (diff < 0) diff = -diff;
         ndiff = tgt - ramp_speed;
         if (ndiff < 0) ndiff = -ndiff;
         if (diff == 0) begin
            ramp_reached = 1'b1;
            ramp_applied = 0;
         end else begin
            step = (diff < cfg.accel) ? diff : cfg.accel;
            ramp_reached = 1'b0;
            ramp_applied = step;
            // The direction of the move follows the target alone, not the correction.
            s = (tgt > ramp_speed) ? ramp_speed + step : ramp_speed - step;
            if (s > SPD_TOP) s = SPD_TOP;
            if (s < -SPD_TOP) s = -SPD_TOP;
            ramp_speed = s;
            // A clamped magnitude is used as is; only an in-range speed gets the offset.
            if (s > 0) begin
               if (s < cfg.smin) s = cfg.smin;
               else if (s > cfg.smax) s = cfg.smax;
               else s = s + int'(SPEED_OFFSET);
            end else if (s < 0) begin
               if (s > -cfg.smin) s = -cfg.smin;
               else if (s < -cfg.smax) s = -cfg.smax;
               else s = s - int'(SPEED_OFFSET);
            end else begin
               s = int'(SPEED_OFFSET);
            end
            pwm_dir = (s <= 0);
            freq = (s > 0) ? s : -s;
            if (freq <= cfg.fmin) begin
               pwm_period = cfg.pmax;
               pwm_duty = DUTY_ZERO;
            end else if (freq >= cfg.fmax) begin
               pwm_period = cfg.pmin;
               pwm_duty = DUTY_SIXTY;
            end else begin
               q = int'(DIVIDEND) / freq;
               pwm_period = (q > PERIOD_TOP) ? PERIOD_TOP : q;
               pwm_duty = DUTY_HALF;
            end
         end
         ramp_nominal = (ndiff < cfg.accel) ? ndiff : cfg.accel;
         if (tgt < 0) ramp_nominal = -ramp_nominal;
      end
      st.taken   = taken;
      st.reached = ramp_reached;
      st.speed   = ramp_speed[13:0];
      st.last    = ramp_applied[13:0];
      st.nominal = ramp_nominal[14:0];
      st.dir     = pwm_dir;
      st.period  = pwm_period[15:0];
      st.duty    = pwm_duty;
      return st;
   endfunction

   function automatic void cmp_field(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   task automatic check_status(input ramp_status_type got);
      ramp_status_type want;
      if (status_due.size() == 0) begin
         n_errors++;
         $display("%0t: response 0x%h with no request outstanding, expected none", $time, got);
      end else begin
         want = status_due.pop_front();
         cmp_field("step_taken", want.taken, got.taken);
         cmp_field("speed_reached", want.reached, got.reached);
         cmp_field("current_speed", want.speed, got.speed);
         cmp_field("last_step", want.last, got.last);
         cmp_field("nominal_step", want.nominal, got.nominal);
         cmp_field("motor_direction", want.dir, got.dir);
         cmp_field("pwm_period_us", want.period, got.period);
         cmp_field("duty_code", want.duty, got.duty);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ACCEL_STEP:    cfg.accel    = val & 32'h3FFF;
         REG_STEP_INTERVAL: cfg.interval = val & 32'h3FFF_FFFF;
         REG_SPEED_MIN:     cfg.smin     = val & 32'h1FFF;
         REG_SPEED_MAX:     cfg.smax     = val & 32'h1FFF;
         REG_FREQ_MIN:      cfg.fmin     = val & 32'h3FFF;
         REG_FREQ_MAX:      cfg.fmax     = val & 32'h3FFF;
         REG_PERIOD_MIN:    cfg.pmin     = val & 32'hFFFF;
         REG_PERIOD_MAX:    cfg.pmax     = val & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic send_update(input int tgt, input int corr, input int el, input bit known,
                              input ramp_status_type want);
      ramp_status_type pred;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({el[29:0], corr[13:0], tgt[13:0]});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = advance_ramp(tgt, corr, el);
      status_due.push_back(known ? want : pred);
   endtask

   task automatic drain_ramp();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0 || !req_tready) @(posedge clock);
   endtask

   function automatic int pick_elapsed();
      longint e;
      case ($urandom_range(9))
         0:       e = 0;
         1:       e = $urandom_range(EL_TOP);
         2:       e = $urandom_range(cfg.interval);
         default: e = longint'(cfg.interval) + 1 + $urandom_range(2000);
      endcase
      return (e > EL_TOP) ? EL_TOP : int'(e);
   endfunction

   function automatic int pick_corr();
      int c;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: c = 0;
         6, 7, 8:          c = int'($urandom_range(40)) - 20;
         default:          c = int'($urandom_range(16383)) - 8192;
      endcase
      return c;
   endfunction

   function automatic int pick_target();
      int t;
      int span;
      span = 3 * cfg.accel + 10;
      case ($urandom_range(9))
         0, 1, 2: t = ramp_speed + int'($urandom_range(2 * span)) - span;
         3, 4:    t = int'($urandom_range(600)) - 300;
         5:       t = ($urandom_range(1) != 0) ? SPD_TOP : -SPD_TOP - 1;
         default: t = int'($urandom_range(16383)) - 8192;
      endcase
      if (t > SPD_TOP) t = SPD_TOP;
      if (t < -SPD_TOP - 1) t = -SPD_TOP - 1;
      return t;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_status(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      ramp_cfg_type phase_cfg;
      int           sent;
      int           run_tgt;
      int           run_len;
      cfg = '{ACCEL_RESET, INTERVAL_RESET, SPEED_MIN_RESET, SPEED_MAX_RESET,
              FREQ_MIN_RESET, FREQ_MAX_RESET, PER_MIN_RESET, PER_MAX_RESET};
      ramp_speed   = 0;
      ramp_reached = 1'b1;
      ramp_applied = 0;
      ramp_nominal = 0;
      ramp_accum   = 0;
      pwm_dir      = 1'b0;
      pwm_period   = PER_MAX_RESET;
      pwm_duty     = DUTY_ZERO;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         case (directed_plan[i].kind)
            PLAN_WRITE: begin
               drain_ramp();
               write_reg(directed_plan[i].idx, directed_plan[i].val);
            end
            default: begin
               send_update(directed_plan[i].tgt, directed_plan[i].corr, directed_plan[i].el,
                           directed_plan[i].kind == PLAN_KNOWN, directed_plan[i].want);
            end
         endcase
      end
      drain_ramp();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            tx_idle_pct = 7;
            rx_idle_pct = 64;
         end else if (phase < 4) begin
            tx_idle_pct = 64;
            rx_idle_pct = 7;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (phase)
            0: phase_cfg = '{ACCEL_RESET, INTERVAL_RESET, SPEED_MIN_RESET, SPEED_MAX_RESET,
                             FREQ_MIN_RESET, FREQ_MAX_RESET, PER_MIN_RESET, PER_MAX_RESET};
            1: phase_cfg = '{16383, 0, 0, 8191, 0, 16383, 1, 65535};
            2: phase_cfg = '{1, 999999999, 8191, 0, 16383, 1, 65535, 1};
            default: begin
               phase_cfg.accel    = ($urandom_range(1) != 0) ? $urandom_range(64, 1)
                                                            : $urandom_range(16383);
               phase_cfg.interval = ($urandom_range(3) != 0) ? $urandom_range(50000)
                                                            : $urandom_range(999999999);
               phase_cfg.smin     = $urandom_range(300);
               phase_cfg.smax     = ($urandom_range(4) != 0) ? $urandom_range(8191, 1000)
                                                            : $urandom_range(8191);
               phase_cfg.fmin     = $urandom_range(400);
               phase_cfg.fmax     = ($urandom_range(4) != 0) ? $urandom_range(8000, 300)
                                                            : $urandom_range(16383);
               phase_cfg.pmin     = $urandom_range(65535);
               phase_cfg.pmax     = $urandom_range(65535);
            end
         endcase
         write_reg(REG_ACCEL_STEP, phase_cfg.accel);
         write_reg(REG_STEP_INTERVAL, phase_cfg.interval);
         write_reg(REG_SPEED_MIN, phase_cfg.smin);
         write_reg(REG_SPEED_MAX, phase_cfg.smax);
         write_reg(REG_FREQ_MIN, phase_cfg.fmin);
         write_reg(REG_FREQ_MAX, phase_cfg.fmax);
         write_reg(REG_PERIOD_MIN, phase_cfg.pmin);
         write_reg(REG_PERIOD_MAX, phase_cfg.pmax);

         // Mostly runs that hold one target so the ramp can climb and settle; the rest
         // are requests with every field drawn at random.
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(3) == 0) begin
               send_update(int'($urandom_range(16383)) - 8192,
                           int'($urandom_range(16383)) - 8192,
                           $urandom_range(EL_TOP), 1'b0, '0);
               sent++;
            end else begin
               run_tgt = pick_target();
               run_len = $urandom_range(40, 4);
               for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
                  send_update(run_tgt, pick_corr(), pick_elapsed(), 1'b0, '0);
                  sent++;
               end
            end
         end
         drain_ramp();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/srmp_pkg.sv
hw/rtl/srmp_seq.sv
hw/rtl/srmp_div.sv
hw/rtl/srmp_dp.sv
hw/rtl/stepper_speed_ramp.sv
tb/sv/tb.sv
